// File: rtl/clas_pkg.sv
package clas_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 2;
  localparam int ROUND_W  = 3;
  localparam int LUX_W    = 26;
  localparam int SCORE_W  = 12;
  localparam int RK_W     = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CAL_W      = 16;
  localparam int THR_W      = 12;
  localparam int SLOT_N     = 4;
  localparam int THR_REG_W  = SLOT_N * THR_W;

  // Internal widths
  localparam int CNT_W  = 5;
  localparam int SUM_W  = 31;
  localparam int TOT_W  = 15;
  localparam int DVD_W  = 33;
  localparam int DVS_W  = 17;
  localparam int DCNT_W = 6;
  localparam int PROD_W = CAL_W + SCORE_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 12'd3000;
  localparam logic [CAL_W-1:0]   CAL_SAT   = 16'hFFFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MEASURE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CALIB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FAULT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABORT   = 3'd4;

  // Result kinds
  localparam logic [RK_W-1:0] RK_READING  = 3'd0;
  localparam logic [RK_W-1:0] RK_VERDICT  = 3'd1;
  localparam logic [RK_W-1:0] RK_CAL_DONE = 3'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_MEASURE = 2'd1,
    PH_CALIB   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_CAL  = 2'd0,
    OP_MEAN = 2'd1,
    OP_MAP  = 2'd2,
    OP_AVG  = 2'd3
  } div_op_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV      = 9'b000000010,
    S_MAP_CHK  = 9'b000000100,
    S_MUL      = 9'b000001000,
    S_READ_PUT = 9'b000010000,
    S_VSTART   = 9'b000100000,
    S_VERD_PUT = 9'b001000000,
    S_CAL_PUT  = 9'b010000000,
    S_STAT_PUT = 9'b100000000
  } state_t;

endpackage

// File: rtl/calibrated_lux_assay_sequencer_top.sv
// Lux assay sequencer.
// Input channel (in_valid / in_stall) carries commands: start measure, start
// calibration, sample, sensor fault and abort. Result channel (out_valid /
// out_stall) carries slot readings, slot verdicts, calibration results and
// run status. Calibration windows and thresholds must be written on the cfg_
// port only while the block is idle; the block itself does not enforce this.
// A sample that does not complete a reading, and any start or ignored
// command, is taken without leaving idle. A sample that completes a measure
// reading runs a 33-step divide for the rounded mean, a compare and, if the
// mean is inside the window, a multiply and a second 33-step divide for the
// window mapping. After the last reading each of the SLOTS verdicts runs one
// 33-step divide, as does a calibration result; a fault or abort status needs
// none. All divides use the single shared restoring divider, which retires
// one quotient bit per cycle. in_stall is high while an item is in progress.
// A finished result sits in the output register; when the receiver stalls,
// the sequencer holds at its next result until the register frees. Reset
// (rst_n low, synchronous) returns the block to idle with configuration
// registers, sample, slot and round counters and score totals at zero.
module calibrated_lux_assay_sequencer_top #(
  parameter int SLOTS       = 4,
  parameter int ROUNDS      = 3,
  parameter int SAMPLES     = 10,
  parameter int CAL_SAMPLES = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [clas_pkg::CMD_W-1:0]      in_command,
  input  logic [clas_pkg::KIND_W-1:0]     in_test_kind,
  input  logic [clas_pkg::SLOT_W-1:0]     in_calib_slot,
  input  logic [clas_pkg::LUX_W-1:0]      in_sample_milli_lux,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clas_pkg::RK_W-1:0]       out_result_kind,
  output logic [clas_pkg::SLOT_W-1:0]     out_slot_number,
  output logic [clas_pkg::ROUND_W-1:0]    out_round_number,
  output logic [clas_pkg::LUX_W-1:0]      out_raw_value,
  output logic [clas_pkg::SCORE_W-1:0]    out_mapped_score,
  output logic                            out_positive_flag,
  output logic                            out_last_of_run
);

  import clas_pkg::*;

  // Configuration
  logic [CFG_DATA_W-1:0] cal_lo_r, cal_hi_r;
  logic [THR_REG_W-1:0]  thr_r;

  // Sequencer state
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [ROUND_W-1:0]  round_r, round_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [TOT_W-1:0]    tot_r [SLOT_N];
  logic [TOT_W-1:0]    tot_nxt [SLOT_N];
  logic [CMD_W-1:0]    stat_kind_r, stat_kind_nxt;

  // Shared divider and datapath
  div_op_t             op_r, op_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [LUX_W-1:0]    mean_r, mean_nxt;
  logic [CAL_W-1:0]    diff_r, diff_nxt;
  logic [SCORE_W-1:0]  score_r, score_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [RK_W-1:0]     o_kind_r, o_kind_nxt;
  logic [SLOT_W-1:0]   o_slot_r, o_slot_nxt;
  logic [ROUND_W-1:0]  o_rnd_r, o_rnd_nxt;
  logic [LUX_W-1:0]    o_raw_r, o_raw_nxt;
  logic [SCORE_W-1:0]  o_score_r, o_score_nxt;
  logic                o_pos_r, o_pos_nxt;
  logic                o_last_r, o_last_nxt;
  logic                out_load;

  // Combinational helpers
  logic [CAL_W-1:0]    lo, hi, span;
  logic [THR_W-1:0]    thr;
  logic [DVS_W:0]      trial;
  logic                fits;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SLOT_W:0]     slot_inc;
  logic [ROUND_W:0]    round_inc;
  logic                emit_ok;
  logic [PROD_W-1:0]   prod;
  logic [TOT_W-1:0]    avg;

  assign lo        = cal_lo_r[slot_r*CAL_W +: CAL_W];
  assign hi        = cal_hi_r[slot_r*CAL_W +: CAL_W];
  assign span      = hi - lo;
  assign thr       = thr_r[kind_r*THR_W +: THR_W];
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign fits      = trial >= {1'b0, dvs_r};
  assign sum_add   = sum_r + SUM_W'(in_sample_milli_lux);
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign slot_inc  = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign round_inc = {1'b0, round_r} + (ROUND_W+1)'(1);
  assign emit_ok   = !out_valid_r || !out_stall;
  assign prod      = diff_r * SCORE_MAX;
  assign avg       = dvd_r[TOT_W-1:0];

  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    round_nxt     = round_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    tot_nxt       = tot_r;
    stat_kind_nxt = stat_kind_r;
    op_nxt        = op_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    mean_nxt      = mean_r;
    diff_nxt      = diff_r;
    score_nxt     = score_r;
    out_load      = 1'b0;
    o_kind_nxt    = o_kind_r;
    o_slot_nxt    = o_slot_r;
    o_rnd_nxt     = o_rnd_r;
    o_raw_nxt     = o_raw_r;
    o_score_nxt   = o_score_r;
    o_pos_nxt     = o_pos_r;
    o_last_nxt    = o_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_MEASURE, CMD_CALIB: begin
              if (phase_r == PH_IDLE) begin
                round_nxt = '0;
                cnt_nxt   = '0;
                sum_nxt   = '0;
                for (int i = 0; i < SLOT_N; i++) tot_nxt[i] = '0;
                if (in_command == CMD_MEASURE) begin
                  phase_nxt = PH_MEASURE;
                  kind_nxt  = in_test_kind;
                  slot_nxt  = '0;
                end else begin
                  phase_nxt = PH_CALIB;
                  slot_nxt  = in_calib_slot;
                end
              end
            end
            CMD_SAMPLE: begin
              if (phase_r != PH_IDLE) begin
                sum_nxt = sum_add;
                cnt_nxt = cnt_inc;
                rem_nxt = '0;
                dcnt_nxt = DCNT_W'(DVD_W - 1);
                if (phase_r == PH_CALIB && cnt_inc >= CNT_W'(CAL_SAMPLES)) begin
                  sum_nxt   = '0;
                  cnt_nxt   = '0;
                  op_nxt    = OP_CAL;
                  dvd_nxt   = DVD_W'(sum_add);
                  dvs_nxt   = DVS_W'(CAL_SAMPLES);
                  state_nxt = S_DIV;
                end else if (phase_r == PH_MEASURE && cnt_inc >= CNT_W'(SAMPLES)) begin
                  // round half up: (2*sum + n) / (2*n)
                  sum_nxt   = '0;
                  cnt_nxt   = '0;
                  op_nxt    = OP_MEAN;
                  dvd_nxt   = DVD_W'({sum_add, 1'b0}) + DVD_W'(SAMPLES);
                  dvs_nxt   = DVS_W'(2 * SAMPLES);
                  state_nxt = S_DIV;
                end
              end
            end
            CMD_FAULT, CMD_ABORT: begin
              if (phase_r != PH_IDLE) begin
                stat_kind_nxt = in_command;
                state_nxt     = S_STAT_PUT;
              end
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        rem_nxt  = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
        dvd_nxt  = {dvd_r[DVD_W-2:0], fits};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          unique case (op_r)
            OP_CAL:  state_nxt = S_CAL_PUT;
            OP_MEAN: state_nxt = S_MAP_CHK;
            OP_MAP:  state_nxt = S_READ_PUT;
            OP_AVG:  state_nxt = S_VERD_PUT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_MAP_CHK: begin
        mean_nxt = dvd_r[LUX_W-1:0];
        if (dvd_r[LUX_W-1:0] < LUX_W'(lo)) begin
          score_nxt = '0;
          state_nxt = S_READ_PUT;
        end else if (hi <= lo || dvd_r[LUX_W-1:0] > LUX_W'(hi)) begin
          score_nxt = SCORE_MAX;
          state_nxt = S_READ_PUT;
        end else begin
          diff_nxt  = dvd_r[CAL_W-1:0] - lo;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        op_nxt    = OP_MAP;
        dvd_nxt   = DVD_W'(prod);
        dvs_nxt   = DVS_W'(span);
        rem_nxt   = '0;
        dcnt_nxt  = DCNT_W'(DVD_W - 1);
        state_nxt = S_DIV;
      end

      S_READ_PUT: begin
        if (op_r == OP_MAP) begin
          score_nxt = dvd_r[SCORE_W-1:0];
          op_nxt    = OP_MEAN;
        end else if (emit_ok) begin
          out_load    = 1'b1;
          o_kind_nxt  = RK_READING;
          o_slot_nxt  = slot_r;
          o_rnd_nxt   = round_r;
          o_raw_nxt   = mean_r;
          o_score_nxt = score_r;
          o_pos_nxt   = 1'b0;
          o_last_nxt  = 1'b0;
          tot_nxt[slot_r] = tot_r[slot_r] + TOT_W'(score_r);
          state_nxt = S_IDLE;
          if (slot_inc >= (SLOT_W+1)'(SLOTS)) begin
            slot_nxt  = '0;
            round_nxt = round_inc[ROUND_W-1:0];
            if (round_inc >= (ROUND_W+1)'(ROUNDS)) begin
              round_nxt = '0;
              state_nxt = S_VSTART;
            end
          end else begin
            slot_nxt = slot_inc[SLOT_W-1:0];
          end
        end
      end

      S_VSTART: begin
        op_nxt    = OP_AVG;
        dvd_nxt   = DVD_W'(tot_r[slot_r]);
        dvs_nxt   = DVS_W'(ROUNDS);
        rem_nxt   = '0;
        dcnt_nxt  = DCNT_W'(DVD_W - 1);
        state_nxt = S_DIV;
      end

      S_VERD_PUT: begin
        if (emit_ok) begin
          out_load    = 1'b1;
          o_kind_nxt  = RK_VERDICT;
          o_slot_nxt  = slot_r;
          o_rnd_nxt   = '0;
          o_raw_nxt   = '0;
          o_score_nxt = avg[SCORE_W-1:0];
          o_pos_nxt   = avg >= TOT_W'(thr);
          o_last_nxt  = slot_inc >= (SLOT_W+1)'(SLOTS);
          if (slot_inc >= (SLOT_W+1)'(SLOTS)) begin
            slot_nxt  = '0;
            phase_nxt = PH_IDLE;
            state_nxt = S_IDLE;
          end else begin
            slot_nxt  = slot_inc[SLOT_W-1:0];
            state_nxt = S_VSTART;
          end
        end
      end

      S_CAL_PUT: begin
        if (emit_ok) begin
          out_load    = 1'b1;
          o_kind_nxt  = RK_CAL_DONE;
          o_slot_nxt  = slot_r;
          o_rnd_nxt   = '0;
          o_raw_nxt   = (dvd_r > DVD_W'(CAL_SAT)) ? LUX_W'(CAL_SAT) : dvd_r[LUX_W-1:0];
          o_score_nxt = '0;
          o_pos_nxt   = 1'b0;
          o_last_nxt  = 1'b1;
          phase_nxt   = PH_IDLE;
          state_nxt   = S_IDLE;
        end
      end

      S_STAT_PUT: begin
        if (emit_ok) begin
          out_load    = 1'b1;
          o_kind_nxt  = stat_kind_r;
          o_slot_nxt  = slot_r;
          o_rnd_nxt   = (phase_r == PH_MEASURE) ? round_r : '0;
          o_raw_nxt   = '0;
          o_score_nxt = '0;
          o_pos_nxt   = 1'b0;
          o_last_nxt  = 1'b1;
          phase_nxt   = PH_IDLE;
          cnt_nxt     = '0;
          sum_nxt     = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until its transfer, reload in the same cycle if ready
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      kind_r      <= '0;
      round_r     <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      for (int i = 0; i < SLOT_N; i++) tot_r[i] <= '0;
      cal_lo_r    <= '0;
      cal_hi_r    <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      round_r     <= round_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAL_LOW:  cal_lo_r <= cfg_wdata;
          CFG_CAL_HIGH: cal_hi_r <= cfg_wdata;
          CFG_THRESH:   thr_r    <= cfg_wdata[THR_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stat_kind_r <= stat_kind_nxt;
    op_r        <= op_nxt;
    dvd_r       <= dvd_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    mean_r      <= mean_nxt;
    diff_r      <= diff_nxt;
    score_r     <= score_nxt;
    o_kind_r    <= o_kind_nxt;
    o_slot_r    <= o_slot_nxt;
    o_rnd_r     <= o_rnd_nxt;
    o_raw_r     <= o_raw_nxt;
    o_score_r   <= o_score_nxt;
    o_pos_r     <= o_pos_nxt;
    o_last_r    <= o_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = o_kind_r;
  assign out_slot_number   = o_slot_r;
  assign out_round_number  = o_rnd_r;
  assign out_raw_value     = o_raw_r;
  assign out_mapped_score  = o_score_r;
  assign out_positive_flag = o_pos_r;
  assign out_last_of_run   = o_last_r;

  // Partial remainder stays below the divisor through every step
  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

  // Verdicts are only produced inside a measure run
  a_verd_phase : assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == S_VERD_PUT |-> phase_r == PH_MEASURE)
    else $error("verdict outside measure run");

  // Every loaded score lies in the mapped range
  a_score_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_mapped_score <= SCORE_MAX)
    else $error("mapped score above range");

  // Sample counter is cleared before it reaches the reading length
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MEASURE |-> cnt_r < CNT_W'(SAMPLES)) and
    (phase_r == PH_CALIB |-> cnt_r < CNT_W'(CAL_SAMPLES)))
    else $error("sample counter overran");

endmodule
